// ===== hw/rtl/tcfls_pkg.sv =====
// Shared types and constants for the two-cluster flip local search unit.
`default_nettype none
package tcfls_pkg;
  localparam int unsigned VertexW = 5;
  localparam int unsigned RowW    = 32;
  localparam int unsigned GainW   = 7;
  localparam int unsigned CountW  = 6;
  localparam int unsigned FlipW   = 9;
  localparam int unsigned LimitN  = 32;

  localparam logic FuncLoad = 1'b0;
  localparam logic FuncRun  = 1'b1;

  // Command broadcast from the sequencer to every cell.
  typedef enum logic [1:0] {
    CellHold = 2'd0,
    CellInit = 2'd1,
    CellFlip = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e            op;
    logic [VertexW-1:0]  vtx;      // partner vertex
    logic                vlabel;   // partner label
    logic [RowW-1:0]     vrow;     // partner row
    logic [VertexW-1:0]  n_last;   // last vertex in use
  } cell_cmd_t;
endpackage
`default_nettype wire

// ===== hw/rtl/two_cluster_flip_local_search_unit.sv =====
// Top level: vertex cell chain plus run sequencer.
//
// Usage: a transaction is taken when start_i is high and busy_o is low.
// func_i = 0 loads vertex_index_i's row and start label; busy_o stays low,
// so loads can follow back to back.
// func_i = 1 runs the search and then reports one result per vertex in use,
// in index order, each shown for one cycle on done_o; last_result_o marks
// the final one. cfg_we_i writes vertex_count; the user must do so only
// while idle, as the block does not enforce it. With N vertices in use and
// F flips, a run first builds gains (one partner vertex per cycle, all cells
// in parallel), then alternates max scans, F+1 scans in all (the maximum
// moves one cell per cycle through the registered chain of 32 cells), with
// flips; each flip walks the N vertices, all gains update in its first step
// and the label flips in its last; then the results follow. The next
// transaction can be taken while the last result is shown. Reset clears
// control state and sets vertex_count to 32; rows and labels are undefined
// until loaded. The receiver cannot stall; results are never held.
`default_nettype none
module two_cluster_flip_local_search_unit #(
  parameter int unsigned MAX_VERTICES = 32
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        start_i,
  output logic       busy_o,
  input  wire        func_i,
  input  wire [4:0]  vertex_index_i,
  input  wire [31:0] adjacency_row_i,
  input  wire        start_label_i,
  input  wire        cfg_we_i,
  input  wire [5:0]  cfg_wdata_i,
  output logic       done_o,
  output logic [4:0] out_vertex_o,
  output logic       final_label_o,
  output logic [8:0] flip_count_o,
  output logic       last_result_o
);
  localparam int unsigned NCells = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
  localparam int unsigned VW = tcfls_pkg::VertexW;
  localparam int unsigned GW = tcfls_pkg::GainW;

  typedef enum logic [2:0] {
    StIdle, StInit, StScan, StFlip, StEmit
  } state_e;

  state_e                      state_q;
  logic [5:0]                  vcount_q;
  logic [VW-1:0]               nlast_q, ptr_q, vsel_q;
  logic [5:0]                  scan_q;
  logic [8:0]                  flips_q;
  logic                        accept;
  tcfls_pkg::cell_cmd_t        cmd;
  logic signed [GW-1:0]        gchain [NCells+1];
  logic [VW-1:0]               ichain [NCells+1];
  logic [tcfls_pkg::RowW-1:0]  rows   [NCells];
  logic [NCells-1:0]           labels;
  logic [NCells-1:0]           flip_vec;
  logic [VW-1:0]               nl_calc;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != StIdle);

  // Clamp vertex count into 2..limit.
  always_comb begin
    if (vcount_q < 6'd2) nl_calc = VW'(1);
    else if (32'(vcount_q) > NCells) nl_calc = VW'(NCells - 1);
    else nl_calc = VW'(vcount_q - 6'd1);
  end

  // Broadcast the partner vertex.
  always_comb begin
    cmd.vtx    = ptr_q;
    cmd.vlabel = labels[ptr_q];
    cmd.vrow   = rows[ptr_q];
    cmd.n_last = nlast_q;
    unique case (state_q)
      StInit:  cmd.op = tcfls_pkg::CellInit;
      StFlip:  cmd.op = tcfls_pkg::CellFlip;
      default: cmd.op = tcfls_pkg::CellHold;
    endcase
    if (state_q == StFlip) begin
      // Partner is the flipped vertex, every cell against it.
      cmd.vtx    = vsel_q;
      cmd.vlabel = labels[vsel_q];
      cmd.vrow   = rows[vsel_q];
    end
  end

  // In StFlip each cell is compared once against the flipped vertex; ptr
  // walks so the update is applied exactly once: only on ptr == 0.
  tcfls_pkg::cell_cmd_t ccmd;
  always_comb begin
    ccmd = cmd;
    if (state_q == StFlip && ptr_q != '0) ccmd.op = tcfls_pkg::CellHold;
  end

  assign gchain[0] = '0;
  assign ichain[0] = '0;

  for (genvar g = 0; g < NCells; g++) begin : g_cell
    assign flip_vec[g] = (state_q == StFlip) && (ptr_q == VW'(nlast_q))
                         && (vsel_q == VW'(g));
    tcfls_cell #(.Idx(VW'(g))) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .load_i     (accept && func_i == tcfls_pkg::FuncLoad
                   && vertex_index_i == VW'(g)),
      .row_i      (adjacency_row_i),
      .label_i    (start_label_i),
      .cmd_i      ((state_q == StInit) ? cmd : ccmd),
      .flip_me_i  (flip_vec[g]),
      .max_gain_i (gchain[g]),
      .max_idx_i  (ichain[g]),
      .max_gain_o (gchain[g+1]),
      .max_idx_o  (ichain[g+1]),
      .row_o      (rows[g]),
      .label_o    (labels[g])
    );
  end

  // Sequence the run.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      vcount_q <= 6'd32;
      nlast_q  <= '0;
      ptr_q    <= '0;
      vsel_q   <= '0;
      scan_q   <= '0;
      flips_q  <= '0;
      done_o   <= 1'b0;
      out_vertex_o  <= '0;
      final_label_o <= 1'b0;
      flip_count_o  <= '0;
      last_result_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (cfg_we_i) vcount_q <= cfg_wdata_i;
      unique case (state_q)
        StIdle: begin
          if (accept && func_i == tcfls_pkg::FuncRun) begin
            nlast_q <= nl_calc;
            ptr_q   <= '0;
            flips_q <= '0;
            state_q <= StInit;
          end
        end
        StInit: begin
          if (ptr_q == nlast_q) state_q <= StScan;
          else ptr_q <= ptr_q + VW'(1);
        end
        StScan: begin
          // Wait until the maximum has crossed every cell.
          ptr_q <= '0;
          if (scan_q != 6'(NCells)) scan_q <= scan_q + 6'd1;
          else begin
            scan_q <= '0;
            if (gchain[NCells] > 0) begin
              vsel_q  <= ichain[NCells];
              state_q <= StFlip;
            end else state_q <= StEmit;
          end
        end
        StFlip: begin
          if (ptr_q == nlast_q) begin
            if (flips_q != 9'd511) flips_q <= flips_q + 9'd1;
            state_q <= StScan;
          end else ptr_q <= ptr_q + VW'(1);
        end
        StEmit: begin
          done_o        <= 1'b1;
          out_vertex_o  <= ptr_q;
          final_label_o <= labels[ptr_q];
          flip_count_o  <= flips_q;
          last_result_o <= (ptr_q == nlast_q);
          if (ptr_q == nlast_q) state_q <= StIdle;
          else ptr_q <= ptr_q + VW'(1);
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Checks.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && ptr_q == nlast_q) |=> state_q == StIdle)
    else $error("emit did not end after last vertex");
  a_done_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == StEmit)
    else $error("result outside emit");
  a_scan_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan && scan_q == 6'(NCells) && gchain[NCells] <= 0)
    |=> state_q == StEmit)
    else $error("search did not stop");
endmodule
`default_nettype wire

// ===== hw/rtl/tcfls_cell.sv =====
// One vertex cell: holds row, label and gain, and forwards a running maximum.
`default_nettype none
module tcfls_cell #(
  parameter logic [tcfls_pkg::VertexW-1:0] Idx = '0
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              load_i,
  input  wire [tcfls_pkg::RowW-1:0]        row_i,
  input  wire                              label_i,
  input  wire tcfls_pkg::cell_cmd_t        cmd_i,
  input  wire                              flip_me_i,
  input  wire signed [tcfls_pkg::GainW-1:0] max_gain_i,
  input  wire [tcfls_pkg::VertexW-1:0]     max_idx_i,
  output logic signed [tcfls_pkg::GainW-1:0] max_gain_o,
  output logic [tcfls_pkg::VertexW-1:0]    max_idx_o,
  output logic [tcfls_pkg::RowW-1:0]       row_o,
  output logic                             label_o
);
  logic [tcfls_pkg::RowW-1:0]         row_q;
  logic                               label_q;
  logic signed [tcfls_pkg::GainW-1:0] gain_q, gain_d, base;
  logic                               joined, agree, active;

  // Pair joined by the lower vertex's row.
  always_comb begin
    if (Idx < cmd_i.vtx) joined = row_q[cmd_i.vtx];
    else                 joined = cmd_i.vrow[Idx];
    agree  = (joined == (label_q == cmd_i.vlabel));
    active = (Idx <= cmd_i.n_last) && (Idx != cmd_i.vtx);
  end

  // Accumulate gain changes for one partner per cycle; start from zero on the first partner.
  always_comb begin
    base   = (cmd_i.vtx == '0) ? '0 : gain_q;
    gain_d = gain_q;
    unique case (cmd_i.op)
      tcfls_pkg::CellInit: begin
        if (active) gain_d = agree ? base - 7'sd1 : base + 7'sd1;
        else gain_d = base;
      end
      tcfls_pkg::CellFlip: begin
        if (active) gain_d = agree ? gain_q + 7'sd2 : gain_q - 7'sd2;
        else if (Idx == cmd_i.vtx) gain_d = -gain_q;
      end
      default: gain_d = gain_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      row_q   <= row_i;
      label_q <= label_i;
      gain_q  <= '0;
    end else begin
      gain_q <= gain_d;
      if (flip_me_i) label_q <= ~label_q;
    end
  end

  // Pass the larger gain to the next cell each cycle; lower index wins ties.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_gain_o <= '0;
      max_idx_o  <= '0;
    end else if (Idx <= cmd_i.n_last && (Idx == '0 || gain_q > max_gain_i)) begin
      max_gain_o <= gain_q;
      max_idx_o  <= Idx;
    end else begin
      max_gain_o <= max_gain_i;
      max_idx_o  <= max_idx_i;
    end
  end

  assign row_o   = row_q;
  assign label_o = label_q;
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the two-cluster flip local search unit.
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  localparam int unsigned WatchdogLimit = 250000;
  localparam int unsigned SettleCycles  = 64;
  localparam int unsigned RandomItems   = 320;

  typedef struct {
    logic [4:0] vertex;
    logic       label;
    logic [8:0] flips;
    logic       last;
  } label_report_t;

  // Predicts per-vertex final labels and compares reported results.
  class label_scoreboard;
    logic [31:0]   rows [32];
    logic          labels [32];
    logic [5:0]    vcount;
    label_report_t pending [$];
    int unsigned   errors;

    function new();
      vcount = 6'd32;
      errors = 0;
      for (int i = 0; i < 32; i++) begin
        rows[i] = '0;
        labels[i] = 1'b0;
      end
    endfunction

    function void report(string msg);
      errors++;
      $display("tb: mismatch at %0t: %s", $time, msg);
    endfunction

    function bit linked(int a, int b);
      int lo;
      int hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      return rows[lo][hi];
    endfunction

    function bit consistent(int a, int b);
      return linked(a, b) == (labels[a] == labels[b]);
    endfunction

    // Note an accepted transaction; a run queues one report per vertex.
    function void note_input(logic func, logic [4:0] idx, logic [31:0] row, logic lbl);
      int n;
      int gain [32];
      int best;
      int top;
      int flips;
      label_report_t r;
      if (func == tcfls_pkg::FuncLoad) begin
        if (idx < tcfls_pkg::LimitN) begin
          rows[idx] = row;
          labels[idx] = lbl;
        end
        return;
      end
      n = vcount;
      if (n < 2) n = 2;
      if (n > tcfls_pkg::LimitN) n = tcfls_pkg::LimitN;
      for (int i = 0; i < 32; i++) gain[i] = 0;
      for (int i = 0; i < n; i++)
        for (int j = i + 1; j < n; j++) begin
          gain[i] += consistent(i, j) ? -1 : 1;
          gain[j] += consistent(i, j) ? -1 : 1;
        end
      flips = 0;
      forever begin
        best = 0;
        top = gain[0];
        for (int i = 1; i < n; i++)
          if (gain[i] > top) begin
            top = gain[i];
            best = i;
          end
        if (top <= 0) break;
        gain[best] = 0;
        for (int i = 0; i < n; i++) begin
          if (i == best) continue;
          if (consistent(i, best)) begin
            gain[i] += 2;
            gain[best] += 1;
          end else begin
            gain[i] -= 2;
            gain[best] -= 1;
          end
        end
        labels[best] = ~labels[best];
        if (flips < 511) flips++;
      end
      for (int i = 0; i < n; i++) begin
        r.vertex = i[4:0];
        r.label = labels[i];
        r.flips = flips[8:0];
        r.last = (i + 1 == n);
        pending.push_back(r);
      end
    endfunction

    // Compare one reported label against the oldest prediction.
    function void check(logic [4:0] vtx, logic lbl, logic [8:0] flips, logic last);
      label_report_t r;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result vertex %0d", vtx));
        return;
      end
      r = pending.pop_front();
      if (vtx !== r.vertex) report($sformatf("vertex %0d exp %0d", vtx, r.vertex));
      if (lbl !== r.label)
        report($sformatf("vertex %0d label %0b exp %0b", r.vertex, lbl, r.label));
      if (flips !== r.flips)
        report($sformatf("vertex %0d flips %0d exp %0d", r.vertex, flips, r.flips));
      if (last !== r.last)
        report($sformatf("vertex %0d last %0b exp %0b", r.vertex, last, r.last));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        func_i;
  logic [4:0]  vertex_index_i;
  logic [31:0] adjacency_row_i;
  logic        start_label_i;
  logic        cfg_we_i;
  logic [5:0]  cfg_wdata_i;
  logic        done_o;
  logic [4:0]  out_vertex_o;
  logic        final_label_o;
  logic [8:0]  flip_count_o;
  logic        last_result_o;

  label_scoreboard sb;
  int unsigned     stalled;
  int unsigned     items;
  bit              no_gaps;
  logic [5:0]      corner_counts [6];

  two_cluster_flip_local_search_unit #(.MAX_VERTICES(32)) u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .func_i, .vertex_index_i, .adjacency_row_i,
    .start_label_i, .cfg_we_i, .cfg_wdata_i, .done_o, .out_vertex_o, .final_label_o,
    .flip_count_o, .last_result_o
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Check every result strobe.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check(out_vertex_o, final_label_o, flip_count_o, last_result_o);
  end

  // Abort when nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stalled <= 0;
    end else if (stalled >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      stalled <= stalled + 1;
    end
  end

  task automatic idle_gap();
    int g;
    if (no_gaps || $urandom_range(0, 2) == 0) return;
    g = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    start_i <= 1'b0;
    repeat (g) @(posedge clk_i);
  endtask

  // Drive one transaction and hold it until accepted.
  task automatic send(logic func, logic [4:0] idx, logic [31:0] row, logic lbl);
    idle_gap();
    start_i <= 1'b1;
    func_i <= func;
    vertex_index_i <= idx;
    adjacency_row_i <= row;
    start_label_i <= lbl;
    do @(posedge clk_i); while (busy_o);
    sb.note_input(func, idx, row, lbl);
    items++;
  endtask

  // Drain results, let the block settle, then write vertex_count.
  task automatic set_count(logic [5:0] value);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.vcount = value;
  endtask

  function automatic logic [31:0] pick_row();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    sb = new();
    stalled = 0;
    items = 0;
    no_gaps = 1'b0;
    corner_counts = '{6'd0, 6'd1, 6'd2, 6'd63, 6'd33, 6'd32};
    start_i = 1'b0;
    func_i = tcfls_pkg::FuncLoad;
    vertex_index_i = '0;
    adjacency_row_i = '0;
    start_label_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every vertex so no run reads an unloaded entry.
    for (int i = 0; i < 32; i++)
      send(tcfls_pkg::FuncLoad, i[4:0], pick_row(), 1'($urandom_range(0, 1)));
    send(tcfls_pkg::FuncRun, '0, '0, 1'b0);
    send(tcfls_pkg::FuncRun, '0, '0, 1'b0);
    // Vertex count extremes, including values that clamp.
    for (int k = 0; k < 6; k++) begin
      set_count(corner_counts[k]);
      send(tcfls_pkg::FuncLoad, 5'd0, 32'hFFFF_FFFF, 1'b1);
      send(tcfls_pkg::FuncLoad, 5'd1, 32'h0000_0000, 1'b0);
      send(tcfls_pkg::FuncRun, '0, '0, 1'b0);
    end

    // Random phases: mostly small graphs, a few full-size ones.
    while (items < RandomItems) begin
      set_count(($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(2, 12)));
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(0, 8))
        send(tcfls_pkg::FuncLoad, 5'($urandom_range(0, 31)), pick_row(),
             1'($urandom_range(0, 1)));
      repeat ($urandom_range(1, 2))
        send(tcfls_pkg::FuncRun, 5'($urandom()), $urandom(), 1'($urandom_range(0, 1)));
    end

    start_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
